[hdl/tcpq_pkg.sv]
// shared types and constants for the two-class priority queue
`default_nettype none
package tcpq_pkg;

  // default sizes
  localparam int CAPACITY_DEF    = 8;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int CAPACITY_MAX    = 64;

  // threshold register
  localparam int          THRESH_WIDTH = 16;
  localparam logic [15:0] THRESH_RESET = 16'd60;

  // slot position carried to the cells, wide enough for any capacity
  localparam int POS_W = $clog2(CAPACITY_MAX + 1);

  // command codes
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle operation broadcast along the row of cells
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_INSERT = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage
`default_nettype wire

[hdl/tcpq_cell.sv]
// one slot of the queue: holds a value, takes from a neighbor or a new value
`default_nettype none
module tcpq_cell #(
  parameter int INDEX       = 0,
  parameter int VALUE_WIDTH = tcpq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire tcpq_pkg::cell_ctl_t    ctl,
  input  wire logic [VALUE_WIDTH-1:0] new_value,
  input  wire logic [VALUE_WIDTH-1:0] prev_value,
  input  wire logic [VALUE_WIDTH-1:0] next_value,
  output logic      [VALUE_WIDTH-1:0] value
);
  import tcpq_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

  logic [VALUE_WIDTH-1:0] value_next;

  // shift moves each slot one step toward the head; insert opens a gap at pos by moving later slots one step back
  always_comb begin
    value_next = value;
    unique case (ctl.op)
      CELL_SHIFT: value_next = next_value;
      CELL_INSERT: begin
        if (ctl.pos == MY_POS) begin
          value_next = new_value;
        end else if (MY_POS > ctl.pos) begin
          value_next = prev_value;
        end
      end
      default: value_next = value;
    endcase
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

[hdl/two_class_priority_queue_top.sv]
// Two-class priority queue: the result beat follows in the cycle after the accepted beat.
// Throughput one operation per cycle while the output is not stalled; the count update and the one-step
// move through the row of slot cells both finish in the accepting cycle.
// Reset clears the item and high-priority counts and the output valid, and
// loads the threshold with 60; slot contents stay undefined until written.
`default_nettype none
module two_class_priority_queue_top #(
  parameter int CAPACITY    = tcpq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = tcpq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [tcpq_pkg::THRESH_WIDTH-1:0] cfg_wr_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              cmd,
  input  wire logic [VALUE_WIDTH-1:0]            item_value,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             status,
  output logic [VALUE_WIDTH-1:0]                 removed_value,
  output logic [$clog2(CAPACITY+1)-1:0]          occupancy
);
  import tcpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (VALUE_WIDTH > THRESH_WIDTH) ? VALUE_WIDTH : THRESH_WIDTH;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [THRESH_WIDTH-1:0] threshold;
  logic [CNT_W-1:0]        item_count, item_count_next;
  logic [CNT_W-1:0]        high_count, high_count_next;
  logic                    accept;
  logic                    is_full, is_empty, is_high;
  logic [VALUE_WIDTH-1:0]  masked_value;
  cell_ctl_t               ctl;
  status_t                 status_next;
  logic [VALUE_WIDTH-1:0]  removed_next;
  logic [VALUE_WIDTH-1:0]  slot_value [CAPACITY];

  // handshake: the output register parts the two sides
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // stored values are limited to the low 16 bits
  always_comb begin
    masked_value = item_value;
    if (VALUE_WIDTH > THRESH_WIDTH) begin
      masked_value = item_value & VALUE_WIDTH'({THRESH_WIDTH{1'b1}});
    end
  end

  assign is_full  = (item_count == CAP_CNT);
  assign is_empty = (item_count == '0);
  assign is_high  = (CMP_W'(masked_value) >= CMP_W'(threshold));

  // decode the operation and the count updates
  always_comb begin
    ctl.op          = CELL_HOLD;
    ctl.pos         = '0;
    status_next     = ST_DONE;
    removed_next    = '0;
    item_count_next = item_count;
    high_count_next = high_count;
    if (accept) begin
      unique case (cmd_t'(cmd))
        CMD_ENQ: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            ctl.op          = CELL_INSERT;
            item_count_next = item_count + CNT_W'(1);
            if (is_high) begin
              ctl.pos         = POS_W'(high_count);
              high_count_next = high_count + CNT_W'(1);
            end else begin
              ctl.pos = POS_W'(item_count);
            end
          end
        end
        CMD_DEQ: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctl.op          = CELL_SHIFT;
            removed_next    = slot_value[0];
            item_count_next = item_count - CNT_W'(1);
            if (high_count != '0) begin
              high_count_next = high_count - CNT_W'(1);
            end
          end
        end
        default: ctl.op = CELL_HOLD;
      endcase
    end
  end

  // row of slot cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_v, next_v;
    if (i == 0) begin : g_first
      assign prev_v = slot_value[i];
    end else begin : g_mid_prev
      assign prev_v = slot_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_v = slot_value[i];
    end else begin : g_mid_next
      assign next_v = slot_value[i+1];
    end
    tcpq_cell #(
      .INDEX       (i),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_value  (masked_value),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (slot_value[i])
    );
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // counts
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      high_count <= '0;
    end else begin
      item_count <= item_count_next;
      high_count <= high_count_next;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      removed_value <= removed_next;
      occupancy     <= item_count_next;
    end
  end

  // checks
  a_high_le_count: assert property (@(posedge clk) disable iff (rst)
    high_count <= item_count) else $error("high count exceeds item count");

  a_count_le_cap: assert property (@(posedge clk) disable iff (rst)
    item_count <= CAP_CNT) else $error("item count exceeds capacity");

  a_occ_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> (occupancy == item_count))
    else $error("occupancy does not match count");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_ENQ && is_full) |=> (item_count == $past(item_count)))
    else $error("rejected enqueue changed count");

endmodule
`default_nettype wire
